>>> src/met_pkg.sv
`timescale 1ns / 1ps

package met_pkg;

   localparam int INDEX_BITS    = 12;
   localparam int COORD_BITS    = 32;
   localparam int STEP_BITS     = 31;
   localparam int FRAC_BITS     = 28;
   localparam int ITER_BITS     = 16;
   localparam int GRAY_BITS     = 24;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   // index * step and origin + index * step
   localparam int MAP_BITS  = INDEX_BITS + STEP_BITS;
   localparam int SUM_BITS  = MAP_BITS + 2;
   // z after an update: |re| <= 2^30 and |im| <= 2^31 on top of a 32-bit point
   localparam int Z_BITS    = COORD_BITS + 2;
   // magnitude of a component that passed the radius check (at most 2.0)
   localparam int MAG_BITS  = FRAC_BITS + 2;
   localparam int PROD_BITS = 2 * MAG_BITS;
   localparam int WIDE_BITS = PROD_BITS + 1;
   localparam int NUM_BITS  = ITER_BITS + GRAY_BITS;
   localparam int DIV_CNT_BITS = $clog2(GRAY_BITS);

   localparam logic [GRAY_BITS-1:0] GRAY_MAX = 24'hFFFFFF;
   localparam int ESCAPE_RADIUS_SQ = 4;
   localparam int TWO              = 2;
   localparam logic [Z_BITS-1:0] COMPONENT_LIMIT = Z_BITS'(TWO) << FRAC_BITS;
   localparam logic [WIDE_BITS-1:0] ESCAPE_SUM =
      WIDE_BITS'(ESCAPE_RADIUS_SQ) << (2 * FRAC_BITS);

   localparam logic [CSR_IDX_BITS-1:0] CSR_X_ORIGIN = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Y_ORIGIN = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_X_STEP   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Y_STEP   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ITER = 3'd4;

   localparam logic signed [COORD_BITS-1:0] ORIGIN_RESET   = -32'sd536870912;
   localparam logic [STEP_BITS-1:0]         STEP_RESET     = 31'd1073742;
   localparam logic [ITER_BITS-1:0]         MAX_ITER_RESET = 16'd1000;

   typedef struct packed {
      logic load;
      logic map_mul;
      logic map_add;
      logic square;
      logic update;
      logic div_init;
      logic div_step;
   } cmd_type;

   typedef struct packed {
      logic stop;
   } status_type;

endpackage

>>> src/mandelbrot_escape_time_core.sv
`timescale 1ns / 1ps
// a new start is not taken while busy; the block works on one item at a time
// each iteration is a square state (three product multipliers) and an update state,
//   the color takes 24 divider steps
// start is taken in the cycle the previous result is shown; rsp_valid lasts one cycle
// reset: synchronous, active high; returns to idle and reloads the register defaults
module mandelbrot_escape_time_core (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [met_pkg::INDEX_BITS-1:0]             req_x_index,
   input  logic [met_pkg::INDEX_BITS-1:0]             req_y_index,
   output logic                                       rsp_valid,
   output logic [met_pkg::ITER_BITS-1:0]              rsp_escape_count,
   output logic [met_pkg::GRAY_BITS-1:0]              rsp_gray_color,
   output logic [met_pkg::INDEX_BITS-1:0]             rsp_x_index_out,
   output logic [met_pkg::INDEX_BITS-1:0]             rsp_y_index_out,
   input  logic                                       csr_wr_en,
   input  logic [met_pkg::CSR_IDX_BITS-1:0]           csr_index,
   input  logic [met_pkg::CSR_DATA_BITS-1:0]          csr_wdata
);

   logic signed [met_pkg::COORD_BITS-1:0]  x_origin_ff, x_origin_in;
   logic signed [met_pkg::COORD_BITS-1:0]  y_origin_ff, y_origin_in;
   logic [met_pkg::STEP_BITS-1:0]          x_step_ff, x_step_in;
   logic [met_pkg::STEP_BITS-1:0]          y_step_ff, y_step_in;
   logic [met_pkg::ITER_BITS-1:0]          max_iter_ff, max_iter_in;

   met_pkg::cmd_type     cmd;
   met_pkg::status_type  status;

   always_comb begin
      x_origin_in = x_origin_ff;
      y_origin_in = y_origin_ff;
      x_step_in   = x_step_ff;
      y_step_in   = y_step_ff;
      max_iter_in = max_iter_ff;
      if (csr_wr_en) begin
         case (csr_index)
            met_pkg::CSR_X_ORIGIN: x_origin_in = $signed(csr_wdata[met_pkg::COORD_BITS-1:0]);
            met_pkg::CSR_Y_ORIGIN: y_origin_in = $signed(csr_wdata[met_pkg::COORD_BITS-1:0]);
            met_pkg::CSR_X_STEP:   x_step_in   = csr_wdata[met_pkg::STEP_BITS-1:0];
            met_pkg::CSR_Y_STEP:   y_step_in   = csr_wdata[met_pkg::STEP_BITS-1:0];
            met_pkg::CSR_MAX_ITER: max_iter_in = csr_wdata[met_pkg::ITER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= met_pkg::ORIGIN_RESET;
         y_origin_ff <= met_pkg::ORIGIN_RESET;
         x_step_ff   <= met_pkg::STEP_RESET;
         y_step_ff   <= met_pkg::STEP_RESET;
         max_iter_ff <= met_pkg::MAX_ITER_RESET;
      end else begin
         x_origin_ff <= x_origin_in;
         y_origin_ff <= y_origin_in;
         x_step_ff   <= x_step_in;
         y_step_ff   <= y_step_in;
         max_iter_ff <= max_iter_in;
      end
   end

   met_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   met_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_x_index  (req_x_index),
      .req_y_index  (req_y_index),
      .x_origin     (x_origin_ff),
      .y_origin     (y_origin_ff),
      .x_step       (x_step_ff),
      .y_step       (y_step_ff),
      .max_iter     (max_iter_ff),
      .escape_count (rsp_escape_count),
      .gray_color   (rsp_gray_color),
      .x_index_out  (rsp_x_index_out),
      .y_index_out  (rsp_y_index_out)
   );

endmodule

>>> src/met_ctrl.sv
`timescale 1ns / 1ps

module met_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output met_pkg::cmd_type     cmd,
   input  met_pkg::status_type  status
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_MAP_MUL  = 7'b0000010,
      S_MAP_ADD  = 7'b0000100,
      S_SQUARE   = 7'b0001000,
      S_UPDATE   = 7'b0010000,
      S_DIV_INIT = 7'b0100000,
      S_DIVIDE   = 7'b1000000
   } state_type;

   localparam logic [met_pkg::DIV_CNT_BITS-1:0] DIV_LAST =
      met_pkg::DIV_CNT_BITS'(met_pkg::GRAY_BITS - 1);

   state_type                          state_ff, state_in;
   logic [met_pkg::DIV_CNT_BITS-1:0]   div_cnt_ff, div_cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_MAP_MUL;
            end
         end
         S_MAP_MUL: begin
            cmd.map_mul = 1'b1;
            state_in    = S_MAP_ADD;
         end
         S_MAP_ADD: begin
            cmd.map_add = 1'b1;
            state_in    = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.stop ? S_DIV_INIT : S_SQUARE;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            div_cnt_in   = '0;
            state_in     = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a result only follows the last division step
   a_rsp_after_divide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff == S_DIVIDE) && state_ff == S_IDLE))
      else $error("result strobe without a finished division");

   a_div_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (div_cnt_ff <= DIV_LAST))
      else $error("division step counter out of range");

   // iteration work never runs while idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !(cmd.square || cmd.update || cmd.div_step || cmd.div_init))
      else $error("datapath command issued while idle");

endmodule

>>> src/met_datapath.sv
`timescale 1ns / 1ps

module met_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  met_pkg::cmd_type                       cmd,
   output met_pkg::status_type                    status,
   input  logic [met_pkg::INDEX_BITS-1:0]         req_x_index,
   input  logic [met_pkg::INDEX_BITS-1:0]         req_y_index,
   input  logic signed [met_pkg::COORD_BITS-1:0]  x_origin,
   input  logic signed [met_pkg::COORD_BITS-1:0]  y_origin,
   input  logic [met_pkg::STEP_BITS-1:0]          x_step,
   input  logic [met_pkg::STEP_BITS-1:0]          y_step,
   input  logic [met_pkg::ITER_BITS-1:0]          max_iter,
   output logic [met_pkg::ITER_BITS-1:0]          escape_count,
   output logic [met_pkg::GRAY_BITS-1:0]          gray_color,
   output logic [met_pkg::INDEX_BITS-1:0]         x_index_out,
   output logic [met_pkg::INDEX_BITS-1:0]         y_index_out
);

   localparam int IB = met_pkg::INDEX_BITS;
   localparam int CB = met_pkg::COORD_BITS;
   localparam int MB = met_pkg::MAP_BITS;
   localparam int SB = met_pkg::SUM_BITS;
   localparam int ZB = met_pkg::Z_BITS;
   localparam int AB = met_pkg::MAG_BITS;
   localparam int PB = met_pkg::PROD_BITS;
   localparam int WB = met_pkg::WIDE_BITS;
   localparam int TB = met_pkg::ITER_BITS;
   localparam int GB = met_pkg::GRAY_BITS;
   localparam int NB = met_pkg::NUM_BITS;
   localparam int FB = met_pkg::FRAC_BITS;

   function automatic logic signed [CB-1:0] saturate(input logic signed [SB-1:0] v);
      logic fits;
      fits = (&v[SB-1:CB-1]) || !(|v[SB-1:CB-1]);
      if (fits)
         return $signed(v[CB-1:0]);
      else if (v[SB-1])
         return $signed({1'b1, {(CB-1){1'b0}}});
      else
         return $signed({1'b0, {(CB-1){1'b1}}});
   endfunction

   logic [IB-1:0]          xi_ff, xi_in, yi_ff, yi_in;
   logic [MB-1:0]          xprod_ff, xprod_in, yprod_ff, yprod_in;
   logic signed [CB-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZB-1:0]   zx_ff, zx_in, zy_ff, zy_in;
   logic [TB-1:0]          count_ff, count_in;
   logic [PB-1:0]          x2_ff, x2_in, y2_ff, y2_in, xy_ff, xy_in;
   logic                   big_ff, big_in, cross_neg_ff, cross_neg_in;
   logic [TB-1:0]          rem_ff, rem_in;
   logic [GB-1:0]          quo_ff, quo_in;

   logic signed [SB-1:0]   x_sum, y_sum;
   logic [ZB-1:0]          ax, ay;
   logic [AB-1:0]          axm, aym;
   logic signed [WB-1:0]   diff, xy_term, re_w, im_w;
   logic [WB-1:0]          mag_sum;
   logic signed [ZB-1:0]   zx_next, zy_next;
   logic                   escaped;
   logic [NB-1:0]          num;
   logic [TB:0]            trial;
   logic                   fits_d;

   always_comb begin
      x_sum = $signed({{(SB-CB){x_origin[CB-1]}}, x_origin}) + $signed({2'b00, xprod_ff});
      y_sum = $signed({{(SB-CB){y_origin[CB-1]}}, y_origin}) + $signed({2'b00, yprod_ff});

      ax  = zx_ff[ZB-1] ? ZB'(-zx_ff) : ZB'(zx_ff);
      ay  = zy_ff[ZB-1] ? ZB'(-zy_ff) : ZB'(zy_ff);
      // past the limit the products are unused, so the low bits suffice
      axm = ax[AB-1:0];
      aym = ay[AB-1:0];

      diff    = $signed({1'b0, x2_ff}) - $signed({1'b0, y2_ff});
      xy_term = cross_neg_ff ? -$signed({1'b0, xy_ff}) : $signed({1'b0, xy_ff});
      // floor rounding is the arithmetic shift; 2xy keeps one more fraction bit
      re_w    = diff >>> FB;
      im_w    = xy_term >>> (FB - 1);
      zx_next = $signed(re_w[ZB-1:0]) + $signed({{(ZB-CB){cx_ff[CB-1]}}, cx_ff});
      zy_next = $signed(im_w[ZB-1:0]) + $signed({{(ZB-CB){cy_ff[CB-1]}}, cy_ff});

      mag_sum = {1'b0, x2_ff} + {1'b0, y2_ff};
      escaped = big_ff || (mag_sum > met_pkg::ESCAPE_SUM);
      status.stop = escaped || (count_ff == max_iter);

      num   = NB'(count_ff) * NB'(met_pkg::GRAY_MAX);
      trial = {rem_ff, quo_ff[GB-1]};
      fits_d = (trial >= {1'b0, max_iter});
   end

   always_comb begin
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      xprod_in     = xprod_ff;
      yprod_in     = yprod_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      zx_in        = zx_ff;
      zy_in        = zy_ff;
      count_in     = count_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      xy_in        = xy_ff;
      big_in       = big_ff;
      cross_neg_in = cross_neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;

      if (cmd.load) begin
         xi_in = req_x_index;
         yi_in = req_y_index;
      end
      if (cmd.map_mul) begin
         xprod_in = MB'(xi_ff) * MB'(x_step);
         yprod_in = MB'(yi_ff) * MB'(y_step);
      end
      if (cmd.map_add) begin
         cx_in    = saturate(x_sum);
         cy_in    = saturate(y_sum);
         zx_in    = $signed({{(ZB-CB){cx_in[CB-1]}}, cx_in});
         zy_in    = $signed({{(ZB-CB){cy_in[CB-1]}}, cy_in});
         count_in = '0;
      end
      if (cmd.square) begin
         x2_in        = PB'(axm) * PB'(axm);
         y2_in        = PB'(aym) * PB'(aym);
         xy_in        = PB'(axm) * PB'(aym);
         big_in       = (ax > met_pkg::COMPONENT_LIMIT) || (ay > met_pkg::COMPONENT_LIMIT);
         cross_neg_in = zx_ff[ZB-1] ^ zy_ff[ZB-1];
      end
      if (cmd.update && !status.stop) begin
         zx_in    = zx_next;
         zy_in    = zy_next;
         count_in = count_ff + 1'b1;
      end
      // quotient fits the color width since count never exceeds the limit
      if (cmd.div_init) begin
         rem_in = num[NB-1:GB];
         quo_in = num[GB-1:0];
      end
      if (cmd.div_step) begin
         rem_in = fits_d ? TB'(trial - {1'b0, max_iter}) : trial[TB-1:0];
         quo_in = {quo_ff[GB-2:0], fits_d};
      end
   end

   always_ff @(posedge clock) begin
      xi_ff        <= xi_in;
      yi_ff        <= yi_in;
      xprod_ff     <= xprod_in;
      yprod_ff     <= yprod_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      zx_ff        <= zx_in;
      zy_ff        <= zy_in;
      count_ff     <= count_in;
      x2_ff        <= x2_in;
      y2_ff        <= y2_in;
      xy_ff        <= xy_in;
      big_ff       <= big_in;
      cross_neg_ff <= cross_neg_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
   end

   assign escape_count = count_ff;
   assign gray_color   = (max_iter == '0) ? '0 : quo_ff;
   assign x_index_out  = xi_ff;
   assign y_index_out  = yi_ff;

   a_count_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !status.stop) |=> (count_ff == TB'($past(count_ff) + 1'b1)))
      else $error("iteration count did not advance");

   // long division invariant: partial remainder stays below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && max_iter != '0) |-> (rem_ff < max_iter))
      else $error("division remainder out of range");

endmodule

>>> bench/mandelbrot_escape_time_core_test.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_core_test;

   localparam int     INDEX_BITS    = met_pkg::INDEX_BITS;
   localparam int     COORD_BITS    = met_pkg::COORD_BITS;
   localparam int     STEP_BITS     = met_pkg::STEP_BITS;
   localparam int     FRAC_BITS     = met_pkg::FRAC_BITS;
   localparam int     ITER_BITS     = met_pkg::ITER_BITS;
   localparam int     GRAY_BITS     = met_pkg::GRAY_BITS;
   localparam int     CSR_IDX_BITS  = met_pkg::CSR_IDX_BITS;
   localparam int     CSR_DATA_BITS = met_pkg::CSR_DATA_BITS;

   localparam int     CLOCK_HIGH    = 10;
   localparam int     CLOCK_LOW     = 10;
   localparam int     RESET_CYCLES  = 5;
   localparam int     DIRECTED_ROWS = 20;
   localparam int     RANDOM_ITEMS  = 560;
   localparam int     QUIET_TAIL    = 40;
   localparam int     DRAIN_CYCLES  = 64;
   localparam longint RUN_LIMIT_NS  = 40_000_000;
   localparam int     ONE_Q         = 1 << FRAC_BITS;

   localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));
   localparam bit [63:0] RADIUS_Q    = 64'(met_pkg::TWO) << FRAC_BITS;
   localparam bit [63:0] RADIUS_SQ_Q = 64'(met_pkg::ESCAPE_RADIUS_SQ) << FRAC_BITS;

   localparam logic NEW_SETTING  = 1'b1;
   localparam logic SAME_SETTING = 1'b0;
   localparam logic PINNED       = 1'b1;
   localparam logic PREDICTED    = 1'b0;

   typedef struct packed {
      logic [ITER_BITS-1:0]  escape_count;
      logic [GRAY_BITS-1:0]  gray_color;
      logic [INDEX_BITS-1:0] x_index;
      logic [INDEX_BITS-1:0] y_index;
   } pixel_type;

   typedef struct packed {
      logic                     new_setting;
      logic [CSR_DATA_BITS-1:0] x_origin;
      logic [CSR_DATA_BITS-1:0] y_origin;
      logic [CSR_DATA_BITS-1:0] x_step;
      logic [CSR_DATA_BITS-1:0] y_step;
      logic [CSR_DATA_BITS-1:0] max_iter;
      logic [INDEX_BITS-1:0]    x_index;
      logic [INDEX_BITS-1:0]    y_index;
      logic                     pinned;
      logic [ITER_BITS-1:0]     escape_count;
      logic [GRAY_BITS-1:0]     gray_color;
   } sweep_row_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [INDEX_BITS-1:0]    req_x_index;
   logic [INDEX_BITS-1:0]    req_y_index;
   logic                     rsp_valid;
   logic [ITER_BITS-1:0]     rsp_escape_count;
   logic [GRAY_BITS-1:0]     rsp_gray_color;
   logic [INDEX_BITS-1:0]    rsp_x_index_out;
   logic [INDEX_BITS-1:0]    rsp_y_index_out;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   // copy of the register file as the block should hold it
   logic signed [COORD_BITS-1:0] plane_x0;
   logic signed [COORD_BITS-1:0] plane_y0;
   logic [STEP_BITS-1:0]         plane_dx;
   logic [STEP_BITS-1:0]         plane_dy;
   logic [ITER_BITS-1:0]         iter_limit;

   pixel_type expected_pixels[$];
   int        mismatches = 0;
   logic      gaps_on;

   sweep_row_type directed_sweep [DIRECTED_ROWS] = '{
      // reset setting: corners outside the radius or saturated, then two points inside
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd0, 12'd0, PINNED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd4095, 12'd4095, PINNED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd1, 12'd4095, PINNED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd500, 12'd500, PREDICTED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd250, 12'd500, PREDICTED, 16'd0, 24'h000000},
      // zero iteration limit, upper data bits set beyond the step and limit registers' widths
      '{NEW_SETTING, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000,
        32'hFFFF_0000, 12'd0, 12'd0, PINNED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd4095, 12'd4095, PINNED, 16'd0, 24'h000000},
      // limit of one at the origin: never escapes, full scale gray
      '{NEW_SETTING, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0001, 12'd0, 12'd0, PINNED, 16'd1, 24'hFFFFFF},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd4095, 12'd0, PINNED, 16'd1, 24'hFFFFFF},
      // most negative origins, widest steps, largest limit
      '{NEW_SETTING, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h0000_FFFF, 12'd0, 12'd0, PINNED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd4095, 12'd4095, PINNED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd1, 12'd1, PINNED, 16'd65535, 24'hFFFFFF},
      // most positive origins
      '{NEW_SETTING, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0002, 12'd2048, 12'd2048, PINNED, 16'd0, 24'h000000},
      // |z|^2 exactly 4 at c = 2 and c = -2
      '{NEW_SETTING, 32'h2000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0007, 12'd0, 12'd0, PREDICTED, 16'd0, 24'h000000},
      '{NEW_SETTING, 32'hE000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0007, 12'd3, 12'd3, PREDICTED, 16'd0, 24'h000000},
      // window over the set, mixed signs for floor rounding
      '{NEW_SETTING, 32'hE000_0000, 32'hEC00_0000, 32'h0004_0000, 32'h0004_0000,
        32'd50, 12'd1024, 12'd1024, PREDICTED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd600, 12'd300, PREDICTED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd3000, 12'd2000, PREDICTED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd4095, 12'd4095, PREDICTED, 16'd0, 24'h000000},
      '{SAME_SETTING, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        12'd800, 12'd1280, PREDICTED, 16'd0, 24'h000000}
   };

   mandelbrot_escape_time_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_x_index      (req_x_index),
      .req_y_index      (req_y_index),
      .rsp_valid        (rsp_valid),
      .rsp_escape_count (rsp_escape_count),
      .rsp_gray_color   (rsp_gray_color),
      .rsp_x_index_out  (rsp_x_index_out),
      .rsp_y_index_out  (rsp_y_index_out),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #CLOCK_LOW;
      clock = 1'b1;
      #CLOCK_HIGH;
   end

   function automatic longint map_coord(logic signed [COORD_BITS-1:0] origin,
                                        logic [STEP_BITS-1:0] step,
                                        logic [INDEX_BITS-1:0] idx);
      longint v;
      v = longint'(origin) + longint'(idx) * longint'(step);
      if (v > COORD_MAX)
         v = COORD_MAX;
      if (v < COORD_MIN)
         v = COORD_MIN;
      return v;
   endfunction

   function automatic bit [63:0] abs_q(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint shift_floor(bit neg, bit [63:0] mag, int sh);
      bit [63:0] q;
      q = mag >> sh;
      if (!neg)
         return longint'(q);
      if ((mag & ((64'd1 << sh) - 64'd1)) != 64'd0)
         q = q + 64'd1;
      return -longint'(q);
   endfunction

   function automatic bit has_escaped(longint zx, longint zy);
      bit [63:0] ax;
      bit [63:0] ay;
      bit [63:0] sum;
      bit [63:0] hi;
      ax = abs_q(zx);
      ay = abs_q(zy);
      // a component beyond 2 escapes before any squaring
      if (ax > RADIUS_Q || ay > RADIUS_Q)
         return 1'b1;
      sum = ax * ax + ay * ay;
      hi = sum >> FRAC_BITS;
      if (hi != RADIUS_SQ_Q)
         return hi > RADIUS_SQ_Q;
      return sum[FRAC_BITS-1:0] != '0;
   endfunction

   function automatic pixel_type predict_pixel(logic [INDEX_BITS-1:0] xi,
                                               logic [INDEX_BITS-1:0] yi);
      pixel_type   px;
      longint      cx;
      longint      cy;
      longint      zx;
      longint      zy;
      longint      re;
      longint      im;
      bit [63:0]   ax;
      bit [63:0]   ay;
      bit [63:0]   x2;
      bit [63:0]   y2;
      bit [63:0]   xy_prod;
      bit [63:0]   gray;
      bit          dneg;
      int unsigned count;
      cx = map_coord(plane_x0, plane_dx, xi);
      cy = map_coord(plane_y0, plane_dy, yi);
      zx = cx;
      zy = cy;
      count = 0;
      while (count < iter_limit && !has_escaped(zx, zy)) begin
         ax = abs_q(zx);
         ay = abs_q(zy);
         x2 = ax * ax;
         y2 = ay * ay;
         xy_prod = ax * ay;
         dneg = x2 < y2;
         re = shift_floor(dneg, dneg ? y2 - x2 : x2 - y2, FRAC_BITS);
         // doubling folded into the shift, so 2xy is rounded once
         im = shift_floor(((zx < 0) != (zy < 0)) && xy_prod != 64'd0, xy_prod,
                          FRAC_BITS - 1);
         zx = re + cx;
         zy = im + cy;
         count++;
      end
      gray = '0;
      if (iter_limit != '0)
         gray = (64'(met_pkg::GRAY_MAX) * 64'(count)) / 64'(iter_limit);
      px.escape_count = ITER_BITS'(count);
      px.gray_color   = GRAY_BITS'(gray);
      px.x_index      = xi;
      px.y_index      = yi;
      return px;
   endfunction

   function automatic logic [INDEX_BITS-1:0] pick_index();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return INDEX_BITS'($urandom);
      endcase
   endfunction

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      case (idx)
         met_pkg::CSR_X_ORIGIN: plane_x0 = data;
         met_pkg::CSR_Y_ORIGIN: plane_y0 = data;
         met_pkg::CSR_X_STEP:   plane_dx = data[STEP_BITS-1:0];
         met_pkg::CSR_Y_STEP:   plane_dy = data[STEP_BITS-1:0];
         met_pkg::CSR_MAX_ITER: iter_limit = data[ITER_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic load_setting(logic [CSR_DATA_BITS-1:0] x0, logic [CSR_DATA_BITS-1:0] y0,
                               logic [CSR_DATA_BITS-1:0] dx, logic [CSR_DATA_BITS-1:0] dy,
                               logic [CSR_DATA_BITS-1:0] lim);
      wait_idle();
      write_reg(met_pkg::CSR_X_ORIGIN, x0);
      write_reg(met_pkg::CSR_Y_ORIGIN, y0);
      write_reg(met_pkg::CSR_X_STEP, dx);
      write_reg(met_pkg::CSR_Y_STEP, dy);
      write_reg(met_pkg::CSR_MAX_ITER, lim);
      // writes past the last register must leave the setting alone
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_IDX_BITS'($urandom_range(met_pkg::CSR_MAX_ITER + 1,
                                                (1 << CSR_IDX_BITS) - 1)),
                   $urandom);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_pixel(logic [INDEX_BITS-1:0] xi, logic [INDEX_BITS-1:0] yi,
                             logic pinned, logic [ITER_BITS-1:0] count,
                             logic [GRAY_BITS-1:0] gray);
      pixel_type want;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start = 1'b1;
      req_x_index = xi;
      req_y_index = yi;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      if (pinned) begin
         want.escape_count = count;
         want.gray_color   = gray;
         want.x_index      = xi;
         want.y_index      = yi;
      end else begin
         want = predict_pixel(xi, yi);
      end
      expected_pixels.push_back(want);
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            $error("pixel result with no item pending: escape_count %0d", rsp_escape_count);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_escape_count !== want.escape_count) begin
               $error("escape_count: expected %0d, got %0d", want.escape_count, rsp_escape_count);
               mismatches++;
            end
            if (rsp_gray_color !== want.gray_color) begin
               $error("gray_color: expected %h, got %h", want.gray_color, rsp_gray_color);
               mismatches++;
            end
            if (rsp_x_index_out !== want.x_index) begin
               $error("x_index_out: expected %0d, got %0d", want.x_index, rsp_x_index_out);
               mismatches++;
            end
            if (rsp_y_index_out !== want.y_index) begin
               $error("y_index_out: expected %0d, got %0d", want.y_index, rsp_y_index_out);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int                       left;
      int                       batch;
      int unsigned              pick;
      logic [CSR_DATA_BITS-1:0] x0;
      logic [CSR_DATA_BITS-1:0] y0;
      logic [CSR_DATA_BITS-1:0] dx;
      logic [CSR_DATA_BITS-1:0] dy;
      logic [CSR_DATA_BITS-1:0] lim;
      reset       = 1'b1;
      start       = 1'b0;
      req_x_index = '0;
      req_y_index = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      gaps_on     = 1'b1;
      plane_x0    = met_pkg::ORIGIN_RESET;
      plane_y0    = met_pkg::ORIGIN_RESET;
      plane_dx    = met_pkg::STEP_RESET;
      plane_dy    = met_pkg::STEP_RESET;
      iter_limit  = met_pkg::MAX_ITER_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_sweep[r]) begin
         if (directed_sweep[r].new_setting)
            load_setting(directed_sweep[r].x_origin, directed_sweep[r].y_origin,
                         directed_sweep[r].x_step, directed_sweep[r].y_step,
                         directed_sweep[r].max_iter);
         send_pixel(directed_sweep[r].x_index, directed_sweep[r].y_index,
                    directed_sweep[r].pinned, directed_sweep[r].escape_count,
                    directed_sweep[r].gray_color);
      end

      left = RANDOM_ITEMS;
      while (left > 0) begin
         // default: a window of about 3 x 3 over the set, short limits
         pick = $urandom_range(0, 99);
         x0  = 32'(-(5 * ONE_Q / 2)) + $urandom_range(0, ONE_Q);
         y0  = 32'(-(3 * ONE_Q / 2)) + $urandom_range(0, ONE_Q);
         dx  = $urandom_range(ONE_Q / 16384, 3 * ONE_Q / 4096);
         dy  = $urandom_range(ONE_Q / 16384, 3 * ONE_Q / 4096);
         lim = $urandom_range(1, 48);
         if (pick < 10) begin
            lim = $urandom_range(0, 1);
         end else if (pick < 25) begin
            // zoomed in near the boundary, where counts spread out
            x0  = 32'(-ONE_Q) + $urandom_range(0, ONE_Q / 2);
            y0  = 32'(-(ONE_Q / 4)) + $urandom_range(0, ONE_Q / 2);
            dx  = $urandom_range(1, 4096);
            dy  = $urandom_range(1, 4096);
            lim = $urandom_range(20, 120);
         end else if (pick < 37) begin
            x0  = $urandom;
            y0  = $urandom;
            dx  = $urandom;
            dy  = $urandom;
            lim = $urandom_range(1, 64);
         end else if (pick < 45) begin
            // zero steps: every index maps to one point
            x0 = 32'(-2 * ONE_Q) + $urandom_range(0, 4 * ONE_Q);
            y0 = 32'(-2 * ONE_Q) + $urandom_range(0, 4 * ONE_Q);
            dx = '0;
            dy = '0;
         end
         // junk above the step and limit registers' widths
         dx[CSR_DATA_BITS-1] = 1'($urandom);
         dy[CSR_DATA_BITS-1] = 1'($urandom);
         lim[CSR_DATA_BITS-1:ITER_BITS] = (CSR_DATA_BITS - ITER_BITS)'($urandom);
         load_setting(x0, y0, dx, dy, lim);

         batch = $urandom_range(10, 40);
         gaps_on = $urandom_range(0, 3) != 0;
         while (batch > 0 && left > 0) begin
            if (left <= QUIET_TAIL)
               gaps_on = 1'b0;
            send_pixel(pick_index(), pick_index(), PREDICTED, '0, '0);
            batch--;
            left--;
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
